>>> hdl/gcm_pkg.sv
// Package for the greedy change maker: field widths, configuration register
// indexes and the sequencer state type. No dependencies.
package gcm_pkg;

  localparam int unsigned DenomW  = 16;  // denomination and config data width
  localparam int unsigned AmountW = 20;  // amount, coin count and remainder width
  localparam int unsigned CntW    = 3;   // denominations-in-use count width
  localparam int unsigned CfgIdxW = 3;   // configuration register index width
  localparam int unsigned DivCntW = 5;   // divider step counter width

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgIdxCount  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIdxDenomA = 3'd1;

  // Final step of the bit-serial divider, one quotient bit per step
  localparam logic [DivCntW-1:0] DivLastStep = DivCntW'(AmountW - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV,
    ST_OUT
  } gcm_state_e;

endpackage

>>> hdl/greedy_change_maker.sv
// Greedy change maker, top level: config registers, denomination selection,
// shared bit-serial divider and result register. Depends on gcm_pkg.

// The block takes an amount to pay and breaks it into coins greedily over up
// to MAX_DENOMS configured denominations, largest first. Each denomination
// takes the whole quotient of what is still owed and the remainder carries
// on. One result transaction comes out per denomination in use, in
// descending order, carrying the denomination, its coin count, the running
// coin total and the amount still owed; the final one has last_of_run_o set.
// A zero denomination reports zero coins and leaves the amount untouched.
// With no denominations in use, one empty result comes out, marked last,
// with still_owed_o equal to the amount. A count register above MAX_DENOMS
// saturates to MAX_DENOMS, and writes to indexes past the last denomination
// are dropped. Timing: the block takes one amount at a time and stalls its
// input until the last result is taken. For each denomination the block
// first finds the largest one not yet used (one compare per cycle over the k
// denominations in use), then runs the shared restoring divider (one
// quotient bit per cycle), then loads the result register and holds it
// until the result is taken. Configure only while idle.
module greedy_change_maker #(
  parameter int unsigned MAX_DENOMS = 6
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [gcm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gcm_pkg::DenomW-1:0]    cfg_data_i,
  // amount channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [gcm_pkg::AmountW-1:0]   pay_amount_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [gcm_pkg::DenomW-1:0]    denomination_o,
  output logic [gcm_pkg::AmountW-1:0]   coins_of_denom_o,
  output logic [gcm_pkg::AmountW-1:0]   coins_so_far_o,
  output logic [gcm_pkg::AmountW-1:0]   still_owed_o,
  output logic                          last_of_run_o
);
  import gcm_pkg::*;

  localparam int unsigned IdxW = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_DENOMS);

  gcm_state_e state_q, state_d;

  // Configuration registers
  logic [CntW-1:0]    denoms_in_use_q;
  logic [DenomW-1:0]  denom_q [MAX_DENOMS];

  // Sequencer control
  logic [CntW-1:0]       k_q;          // denominations in use for this amount
  logic [CntW-1:0]       round_q;      // result being worked on
  logic [IdxW-1:0]       scan_q;       // denomination under compare
  logic [MAX_DENOMS-1:0] taken_q;      // denominations already reported
  logic                  found_q;      // best_q holds a candidate
  logic [DivCntW-1:0]    div_cnt_q;

  // Datapath
  logic [DenomW-1:0]  best_q;
  logic [IdxW-1:0]    best_idx_q;
  logic [DenomW-1:0]  divisor_q;
  logic [DenomW-1:0]  pr_q;            // partial remainder
  logic [AmountW-1:0] qr_q;            // dividend shifting out, quotient in
  logic [AmountW-1:0] remaining_q;
  logic [AmountW-1:0] total_q;

  // Result register
  logic [DenomW-1:0]  denom_out_q;
  logic [AmountW-1:0] coins_out_q;
  logic [AmountW-1:0] so_far_out_q;
  logic [AmountW-1:0] owed_out_q;
  logic               last_out_q;

  // Combinational helpers
  logic [CntW-1:0]    k_sat;
  logic [DenomW-1:0]  cand;
  logic               pick;
  logic [DenomW-1:0]  best_nx;
  logic [IdxW-1:0]    idx_nx;
  logic               scan_done;
  logic [DenomW:0]    trial;
  logic [DenomW:0]    diff;
  logic               ge;
  logic [DenomW-1:0]  pr_nx;
  logic [AmountW-1:0] qr_nx;
  logic [AmountW-1:0] count_nx;
  logic [AmountW-1:0] owed_nx;
  logic [AmountW-1:0] total_nx;
  logic               last_round;
  logic               div_done;
  logic               accept;

  // Saturate the count register at the number of denomination slots
  assign k_sat = (denoms_in_use_q > MaxCnt) ? MaxCnt : denoms_in_use_q;

  // Selection: keep the largest denomination not yet reported
  assign cand      = denom_q[scan_q];
  assign pick      = !taken_q[scan_q] && (!found_q || (cand > best_q));
  assign best_nx   = pick ? cand : best_q;
  assign idx_nx    = pick ? scan_q : best_idx_q;
  assign scan_done = (CntW'(scan_q) + CntW'(1)) == k_q;

  // Restoring divider step: one quotient bit per cycle
  assign trial = {pr_q, qr_q[AmountW-1]};
  assign diff  = trial - {1'b0, divisor_q};
  assign ge    = trial >= {1'b0, divisor_q};
  assign pr_nx = ge ? diff[DenomW-1:0] : trial[DenomW-1:0];
  assign qr_nx = {qr_q[AmountW-2:0], ge};

  // A zero denomination takes no coins and passes the amount through
  assign count_nx   = (divisor_q == '0) ? '0 : qr_nx;
  assign owed_nx    = (divisor_q == '0) ? remaining_q
                                        : {{(AmountW-DenomW){1'b0}}, pr_nx};
  assign total_nx   = total_q + count_nx;
  assign last_round = (round_q + CntW'(1)) == k_q;
  assign div_done   = div_cnt_q == DivLastStep;
  assign accept     = in_valid_i && !in_stall_o;

  // Next state and handshake outputs
  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = (k_sat == '0) ? ST_OUT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_done) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = last_out_q ? ST_IDLE : ST_SCAN;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers and sequencer counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      denoms_in_use_q <= '0;
      for (int i = 0; i < MAX_DENOMS; i++) begin
        denom_q[i] <= '0;
      end
      k_q       <= '0;
      round_q   <= '0;
      scan_q    <= '0;
      taken_q   <= '0;
      found_q   <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgIdxCount) begin
          denoms_in_use_q <= cfg_data_i[CntW-1:0];
        end else if (32'(cfg_index_i) <= MAX_DENOMS) begin
          denom_q[IdxW'(cfg_index_i - CfgIdxDenomA)] <= cfg_data_i;
        end
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            k_q     <= k_sat;
            round_q <= '0;
            scan_q  <= '0;
            taken_q <= '0;
            found_q <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (scan_done) begin
            taken_q[idx_nx] <= 1'b1;
            found_q         <= 1'b0;
            scan_q          <= '0;
            div_cnt_q       <= '0;
          end else begin
            found_q <= found_q | pick;
            scan_q  <= scan_q + IdxW'(1);
          end
        end
        ST_DIV: begin
          div_cnt_q <= div_cnt_q + DivCntW'(1);
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            round_q <= round_q + CntW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath and result register
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          remaining_q  <= pay_amount_i;
          total_q      <= '0;
          // Empty result, used as is when no denomination is in use
          denom_out_q  <= '0;
          coins_out_q  <= '0;
          so_far_out_q <= '0;
          owed_out_q   <= pay_amount_i;
          last_out_q   <= 1'b1;
        end
      end
      ST_SCAN: begin
        best_q     <= best_nx;
        best_idx_q <= idx_nx;
        if (scan_done) begin
          divisor_q <= best_nx;
          pr_q      <= '0;
          qr_q      <= remaining_q;
        end
      end
      ST_DIV: begin
        pr_q <= pr_nx;
        qr_q <= qr_nx;
        if (div_done) begin
          remaining_q  <= owed_nx;
          total_q      <= total_nx;
          denom_out_q  <= divisor_q;
          coins_out_q  <= count_nx;
          so_far_out_q <= total_nx;
          owed_out_q   <= owed_nx;
          last_out_q   <= last_round;
        end
      end
      default: begin
      end
    endcase
  end

  assign denomination_o   = denom_out_q;
  assign coins_of_denom_o = coins_out_q;
  assign coins_so_far_o   = so_far_out_q;
  assign still_owed_o     = owed_out_q;
  assign last_of_run_o    = last_out_q;

  // An accepted amount goes to selection, or straight to a result if empty
  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_SCAN) || (state_q == ST_OUT))
    else $error("accepted amount did not start a run");

  // Selection never runs past the denominations in use
  a_round_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (round_q < k_q))
    else $error("selection round beyond denominations in use");

  // The divider runs its full number of steps
  a_div_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && !div_done |=> (state_q == ST_DIV))
    else $error("divider left early");

  // The running total includes this denomination's coins
  a_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (coins_of_denom_o <= coins_so_far_o))
    else $error("running coin total below this count");

  // Taking the last result returns the block to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && last_of_run_o |=> (state_q == ST_IDLE))
    else $error("run did not end after last result");

endmodule
